### hw/rtl/ngh_pkg.sv
// Shared types, constants and the control store of the noise gate sequencer.
package ngh_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 24;
    localparam int HOLD_BITS_DEF   = 16;

    localparam longint unsigned ATTACK_RESET    = 64'd16383264;
    localparam longint unsigned RELEASE_RESET   = 64'd16774412;
    localparam longint unsigned THRESHOLD_RESET = 64'd83886;
    localparam longint unsigned RANGE_RESET     = 64'd0;
    localparam longint unsigned HOLD_RESET      = 64'd441;

    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK    = 3'd0,
        REG_RELEASE   = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_RANGE     = 3'd3,
        REG_HOLD      = 3'd4
    } ngh_reg_t;

    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_IN     = 2'd1,
        COND_OUT    = 2'd2
    } ngh_cond_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_ENV  = 2'd1,
        MUL_GAIN = 2'd2,
        MUL_OUT  = 2'd3
    } ngh_mul_op_t;

    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_IN     = 3'd1,
        WR_ENV    = 3'd2,
        WR_DECIDE = 3'd3,
        WR_GAIN   = 3'd4,
        WR_OUT    = 3'd5
    } ngh_wr_op_t;

    typedef struct packed {
        ngh_cond_t          cond;
        logic               jump;
        logic [STEP_W-1:0]  target;
        ngh_mul_op_t        mul_op;
        ngh_wr_op_t         wr_op;
    } ngh_uword_t;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_ENV_MUL  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ENV_WR   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_GAIN_MUL = 3'd3;
    localparam logic [STEP_W-1:0] STEP_GAIN_WR  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_OUT_MUL  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_OUT_WR   = 3'd6;

    function automatic int ngh_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Control store: one word per step.
    function automatic ngh_uword_t ngh_ucode(input logic [STEP_W-1:0] step);
        ngh_uword_t w;
        w = '{cond: COND_ALWAYS, jump: 1'b0, target: STEP_IDLE,
              mul_op: MUL_NONE, wr_op: WR_NONE};
        case (step)
            STEP_IDLE: begin
                w.cond  = COND_IN;
                w.wr_op = WR_IN;
            end
            STEP_ENV_MUL:  w.mul_op = MUL_ENV;
            STEP_ENV_WR:   w.wr_op  = WR_ENV;
            STEP_GAIN_MUL: begin
                w.mul_op = MUL_GAIN;
                w.wr_op  = WR_DECIDE;
            end
            STEP_GAIN_WR:  w.wr_op  = WR_GAIN;
            STEP_OUT_MUL:  w.mul_op = MUL_OUT;
            STEP_OUT_WR: begin
                w.cond   = COND_OUT;
                w.wr_op  = WR_OUT;
                w.jump   = 1'b1;
                w.target = STEP_IDLE;
            end
            default: begin
                w.jump   = 1'b1;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/ngh_mul.sv
// Shared multiplier: unsigned by signed, product registered when enabled.
module ngh_mul import ngh_pkg::*; #(
    parameter int A_W = COEFF_BITS_DEF + 1,
    parameter int B_W = COEFF_BITS_DEF + 2
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [A_W-1:0]           a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W:0]  p_reg
);

    logic signed [A_W:0] a_s;

    assign a_s = $signed({1'b0, a});

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a_s * b;
        end
    end

endmodule

### hw/rtl/noise_gate_hold_range.sv
// Noise gate with peak envelope, hold counter and range floor, microcoded datapath.
//
//   channel   ports                                   direction
//   s_        s_valid s_ready s_sample_in s_start_block  in
//   m_        m_valid m_ready m_sample_out m_gate_open   out
//   cfg_      cfg_we cfg_index cfg_wdata               in (write only)
//
// Each sample runs through a seven-step program that drives one shared multiplier,
// and each of its three products (envelope, gain, output) needs a multiply step
// and a write-back step. s_ready is high only on the idle step.
// The result sits in an output register; the next sample is taken while it waits,
// and the program stalls on its last step only if the previous result is still held.
// Reset is synchronous: state clears, registers take their default settings.
module noise_gate_hold_range import ngh_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF,
    parameter int HOLD_BITS   = HOLD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          s_start_block,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_gate_open,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [ngh_max(ngh_max(SAMPLE_BITS, COEFF_BITS + 1), HOLD_BITS)-1:0] cfg_wdata
);

    localparam int G_W = COEFF_BITS + 1;
    localparam int T_W = ngh_max(SAMPLE_BITS, G_W);
    localparam int D_W = ngh_max(SAMPLE_BITS + 1, COEFF_BITS + 2);
    localparam int P_W = G_W + D_W + 1;

    localparam logic [COEFF_BITS-1:0]  ATTACK_INIT    = COEFF_BITS'(ATTACK_RESET);
    localparam logic [COEFF_BITS-1:0]  RELEASE_INIT   = COEFF_BITS'(RELEASE_RESET);
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_INIT = SAMPLE_BITS'(THRESHOLD_RESET);
    localparam logic [G_W-1:0]         RANGE_INIT     = G_W'(RANGE_RESET);
    localparam logic [HOLD_BITS-1:0]   HOLD_INIT      = HOLD_BITS'(HOLD_RESET);
    localparam logic [G_W-1:0]         UNITY          = {1'b1, {COEFF_BITS{1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic [COEFF_BITS-1:0]  attack_reg, release_reg;
    logic [SAMPLE_BITS-1:0] threshold_reg;
    logic [G_W-1:0]         range_reg;
    logic [HOLD_BITS-1:0]   hold_len_reg;

    // sequencer and state
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SAMPLE_BITS-1:0] env_reg, env_next;
    logic [G_W-1:0]         gain_reg, gain_next;
    logic [HOLD_BITS-1:0]   hold_reg, hold_next;
    logic                   open_reg, open_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [T_W-1:0]         tgt_reg, tgt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_sample_out_reg, m_sample_out_next;
    logic                   m_gate_open_reg, m_gate_open_next;

    ngh_uword_t             uw;
    logic                   go;
    logic                   mul_en;
    logic [G_W-1:0]         mul_a;
    logic signed [D_W-1:0]  mul_b;
    logic signed [P_W-1:0]  p_reg;
    logic signed [P_W-1:0]  p_shift;
    logic signed [P_W-1:0]  sum;
    logic signed [SAMPLE_BITS:0] env_diff;
    logic [G_W-1:0]         range_eff;
    logic                   open_hit;
    logic                   hold_nz;
    logic [G_W-1:0]         gain_tgt;
    logic [SAMPLE_BITS-1:0] prod;

    ngh_mul #(
        .A_W (G_W),
        .B_W (D_W)
    ) u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (p_reg)
    );

    assign uw        = ngh_ucode(step_reg);
    assign range_eff = (range_reg > UNITY) ? UNITY : range_reg;
    assign open_hit  = (env_reg >= threshold_reg);
    assign hold_nz   = (hold_reg != '0);
    assign gain_tgt  = (open_hit || hold_nz) ? UNITY : range_eff;
    assign env_diff  = $signed({1'b0, env_reg}) - $signed({1'b0, mag_reg});
    // smoothing is target + floor(coeff * (state - target) / unity)
    assign p_shift   = p_reg >>> COEFF_BITS;
    assign sum       = p_shift + P_W'($signed({1'b0, tgt_reg}));
    assign prod      = p_shift[SAMPLE_BITS-1:0];

    assign s_ready      = (step_reg == STEP_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_gate_open  = m_gate_open_reg;

    always_comb begin
        step_next         = step_reg;
        env_next          = env_reg;
        gain_next         = gain_reg;
        hold_next         = hold_reg;
        open_next         = open_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        tgt_next          = tgt_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_sample_out_next = m_sample_out_reg;
        m_gate_open_next  = m_gate_open_reg;
        mul_en            = 1'b0;
        mul_a             = '0;
        mul_b             = '0;

        case (uw.cond)
            COND_ALWAYS: go = 1'b1;
            COND_IN:     go = s_valid;
            COND_OUT:    go = !(m_valid_reg && !m_ready);
            default:     go = 1'b1;
        endcase

        if (go) begin
            step_next = uw.jump ? uw.target : step_reg + 1'b1;
        end

        case (uw.mul_op)
            MUL_ENV: begin
                mul_en   = 1'b1;
                mul_a    = {1'b0, (mag_reg > env_reg) ? attack_reg : release_reg};
                mul_b    = D_W'(env_diff);
                tgt_next = T_W'(mag_reg);
            end
            MUL_GAIN: begin
                mul_en   = 1'b1;
                mul_a    = {1'b0, (open_hit || hold_nz) ? attack_reg : release_reg};
                tgt_next = T_W'(gain_tgt);
            end
            MUL_OUT: begin
                mul_en = 1'b1;
                mul_a  = gain_reg;
                mul_b  = D_W'($signed({1'b0, mag_reg}));
            end
            default: mul_en = 1'b0;
        endcase

        // the gain difference needs the target chosen on this same step
        if (uw.mul_op == MUL_GAIN) begin
            mul_b = D_W'($signed({1'b0, gain_reg}) - $signed({1'b0, gain_tgt}));
        end

        case (uw.wr_op)
            WR_IN: begin
                if (go) begin
                    neg_next = s_sample_in[SAMPLE_BITS-1];
                    mag_next = s_sample_in[SAMPLE_BITS-1] ?
                               (~s_sample_in + 1'b1) : s_sample_in;
                    if (s_start_block) begin
                        env_next  = '0;
                        gain_next = '0;
                        hold_next = '0;
                        open_next = 1'b0;
                    end
                end
            end
            WR_ENV: env_next = sum[SAMPLE_BITS-1:0];
            WR_DECIDE: begin
                if (open_hit) begin
                    open_next = 1'b1;
                    hold_next = hold_len_reg;
                end else if (hold_nz) begin
                    hold_next = hold_reg - 1'b1;
                end else begin
                    open_next = 1'b0;
                end
            end
            WR_GAIN: begin
                if (sum < P_W'($signed({1'b0, range_eff}))) begin
                    gain_next = range_eff;
                end else if (sum > P_W'($signed({1'b0, UNITY}))) begin
                    gain_next = UNITY;
                end else begin
                    gain_next = sum[G_W-1:0];
                end
            end
            WR_OUT: begin
                if (go) begin
                    m_valid_next      = 1'b1;
                    m_sample_out_next = neg_reg ? (~prod + 1'b1) : prod;
                    m_gate_open_next  = open_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            env_reg       <= '0;
            gain_reg      <= '0;
            hold_reg      <= '0;
            open_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            attack_reg    <= ATTACK_INIT;
            release_reg   <= RELEASE_INIT;
            threshold_reg <= THRESHOLD_INIT;
            range_reg     <= RANGE_INIT;
            hold_len_reg  <= HOLD_INIT;
        end else begin
            step_reg    <= step_next;
            env_reg     <= env_next;
            gain_reg    <= gain_next;
            hold_reg    <= hold_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ATTACK:    attack_reg    <= cfg_wdata[COEFF_BITS-1:0];
                    REG_RELEASE:   release_reg   <= cfg_wdata[COEFF_BITS-1:0];
                    REG_THRESHOLD: threshold_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                    REG_RANGE:     range_reg     <= cfg_wdata[G_W-1:0];
                    REG_HOLD:      hold_len_reg  <= cfg_wdata[HOLD_BITS-1:0];
                    default: ;
                endcase
            end
        end
        mag_reg          <= mag_next;
        neg_reg          <= neg_next;
        tgt_reg          <= tgt_next;
        m_sample_out_reg <= m_sample_out_next;
        m_gate_open_reg  <= m_gate_open_next;
    end

`ifndef SYNTH
    a_accept_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (step_reg == STEP_ENV_MUL))
        else $error("accepted beat did not start the program");

    a_gain_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= UNITY)
        else $error("gain above unity");

    a_env_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= FULL_SCALE)
        else $error("envelope above full scale");
`endif

endmodule

### verif/noise_gate_hold_range_tb.sv
// Self-checking testbench for the noise gate: directed edge cases, setting sweeps, backpressure.
`timescale 1ns / 1ps

module noise_gate_hold_range_tb import ngh_pkg::*;;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int CW = COEFF_BITS_DEF;
    localparam int CFG_W = ngh_max(ngh_max(SAMPLE_BITS_DEF, COEFF_BITS_DEF + 1), HOLD_BITS_DEF);
    localparam int CLK_HALF = 5;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAUSE = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef bit [63:0] wide_t;
    localparam wide_t UNITY = 64'd1 << CW;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          gate;
    } gated_beat_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_CHOPPY,
        RX_SLOW
    } rx_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [SW-1:0] s_sample_in = '0;
    logic                 s_start_block = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SW-1:0] m_sample_out;
    logic                 m_gate_open;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    noise_gate_hold_range u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_start_block (s_start_block),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_gate_open   (m_gate_open),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Gate settings and state as the predictor sees them
    wide_t cfg_attack, cfg_release, cfg_thresh, cfg_range, cfg_hold;
    wide_t env_lvl, gain_lvl, hold_cnt;
    bit    open_st;

    gated_beat_t gated_q[$];
    gated_beat_t got_beat;
    int          errors = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          holdoff_req = 0;
    int          holdoff_seen = 0;
    int          holdoff_left = 0;
    logic [7:0]  rx_tick = '0;

    function automatic wide_t glide(input wide_t c, input wide_t x, input wide_t t);
        return (c * x + (UNITY - c) * t) >> CW;
    endfunction

    task automatic gate_predict(input logic [SW-1:0] smp, input logic start,
                                output gated_beat_t beat);
        wide_t mag, floor_g, prod, res;
        bit    neg;
        neg = smp[SW-1];
        mag = neg ? (64'd1 << SW) - {40'd0, smp} : {40'd0, smp};
        floor_g = (cfg_range > UNITY) ? UNITY : cfg_range;
        if (start) begin
            env_lvl = 0;
            gain_lvl = 0;
            hold_cnt = 0;
            open_st = 1'b0;
        end
        if (mag > env_lvl)
            env_lvl = glide(cfg_attack, env_lvl, mag);
        else
            env_lvl = glide(cfg_release, env_lvl, mag);
        if (env_lvl >= cfg_thresh) begin
            open_st = 1'b1;
            hold_cnt = cfg_hold;
            gain_lvl = glide(cfg_attack, gain_lvl, UNITY);
        end else if (hold_cnt > 0) begin
            // hold: the gain still rises towards unity
            hold_cnt = hold_cnt - 1;
            gain_lvl = glide(cfg_attack, gain_lvl, UNITY);
        end else begin
            open_st = 1'b0;
            gain_lvl = glide(cfg_release, gain_lvl, floor_g);
        end
        if (gain_lvl < floor_g)
            gain_lvl = floor_g;
        if (gain_lvl > UNITY)
            gain_lvl = UNITY;
        prod = (mag * gain_lvl) >> CW;
        res = neg ? 64'd0 - prod : prod;
        beat.sample = res[SW-1:0];
        beat.gate = open_st;
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (gated_q.size() == 0) begin
                $display("%0t unexpected beat: sample_out %0d gate_open %0b",
                         $time, m_sample_out, m_gate_open);
                errors++;
            end else begin
                got_beat = gated_q.pop_front();
                if (m_sample_out !== got_beat.sample) begin
                    $display("%0t sample_out: expected %0d, got %0d",
                             $time, $signed(got_beat.sample), m_sample_out);
                    errors++;
                end
                if (m_gate_open !== got_beat.gate) begin
                    $display("%0t gate_open: expected %0b, got %0b",
                             $time, got_beat.gate, m_gate_open);
                    errors++;
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (holdoff_left != 0) begin
            m_ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_req) begin
            m_ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_seen <= holdoff_req;
        end else begin
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_CHOPPY: m_ready <= ($urandom_range(0, 99) < 55);
                default:   m_ready <= (rx_tick[2:0] == 3'd0) || (rx_tick[2:0] == 3'd5);
            endcase
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t no beat for %0d cycles", $time, stall_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] smp, input logic start);
        gated_beat_t beat;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_sample_in <= smp;
        s_start_block <= start;
        do @(posedge aclk); while (s_ready !== 1'b1);
        gate_predict(smp, start, beat);
        gated_q.push_back(beat);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (gated_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_ATTACK:    cfg_attack = {40'd0, data[CW-1:0]};
            REG_RELEASE:   cfg_release = {40'd0, data[CW-1:0]};
            REG_THRESHOLD: cfg_thresh = {40'd0, data[SW-1:0]};
            REG_RANGE:     cfg_range = {39'd0, data[CW:0]};
            REG_HOLD:      cfg_hold = {48'd0, data[15:0]};
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] rel,
                              input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] rng,
                              input logic [CFG_W-1:0] hld);
        write_reg(REG_ATTACK, atk);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_THRESHOLD, thr);
        // an unmapped index must leave every register alone
        write_reg(REG_UNUSED, CFG_W'($urandom));
        write_reg(REG_RANGE, rng);
        write_reg(REG_HOLD, hld);
        cfg_we <= 1'b0;
    endtask

    // Passages of loud, quiet, silent and full-range material
    task automatic play_passage(input int n_items);
        int sent, seg_len, kind, magn;
        logic signed [SW-1:0] smp;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            seg_len = $urandom_range(1, 40);
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
                if (kind <= 3)
                    magn = $urandom_range(1 << 20, (1 << 23) - 1);
                else if (kind <= 6)
                    magn = $urandom_range(0, 1 << 12);
                else
                    magn = 0;
                smp = SW'(magn);
                if ($urandom_range(0, 1) == 1)
                    smp = -smp;
                if (kind == 7)
                    smp = SW'($urandom);
                if (kind == 9) begin
                    case ($urandom_range(0, 3))
                        0: smp = 24'h7FFFFF;
                        1: smp = 24'h800000;
                        2: smp = 24'h000001;
                        default: smp = 24'hFFFFFF;
                    endcase
                end
                send_sample(smp, $urandom_range(0, 63) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_reset_values();
        rx_mode <= RX_FREE;
        send_sample(24'h600000, 1'b1);
        for (int k = 0; k < 7; k++)
            send_sample((k % 2) ? -24'sh5A0000 : 24'sh7FFFFF, 1'b0);
        for (int k = 0; k < 6; k++)
            send_sample(24'h000010, 1'b0);
        drain_results();
    endtask

    task automatic test_edge_cases();
        rx_mode <= RX_CHOPPY;
        // instant envelope, hold length zero: closes on the first quiet beat
        set_config(0, 0, 24'h200000, 0, 0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h000001, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h100000, 1'b0);
        drain_results();
        // threshold zero keeps it open; a floor above unity acts as unity
        set_config(24'h800000, 24'h800000, 0, 25'h1FFFFFF, 16'hFFFF);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h000000, 1'b0);
        drain_results();
        // threshold above full scale never opens; unity floor passes the sample
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 25'h1000000, 0);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h123456, 1'b0);
        drain_results();
        // full-scale threshold is reached only by the most negative sample
        set_config(0, 0, 24'h800000, 0, 3);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        drain_results();
    endtask

    task automatic test_setting_sweep();
        rx_mode <= RX_FREE;
        set_config(0, 24'hFFFFFF, $urandom_range(1 << 16, 1 << 21), 25'h1000000, 16'hFFFF);
        play_passage(260);
        drain_results();
        rx_mode <= RX_CHOPPY;
        set_config(24'hFFFFFF, 0, 0, 0, 0);
        play_passage(260);
        drain_results();
        for (int p = 0; p < 4; p++) begin
            case (p % 3)
                0: rx_mode <= RX_CHOPPY;
                1: rx_mode <= RX_SLOW;
                default: rx_mode <= RX_FREE;
            endcase
            set_config($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                       $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 24),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
                                                   : $urandom_range(0, 60));
            play_passage(260);
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        rx_mode <= RX_FREE;
        set_config($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                   $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 24),
                   $urandom_range(0, 30));
        // keep offering while the receiver holds off, so the input stalls
        holdoff_req <= holdoff_req + 1;
        play_passage(40);
        drain_results();
    endtask

    initial begin
        cfg_attack = ATTACK_RESET;
        cfg_release = RELEASE_RESET;
        cfg_thresh = THRESHOLD_RESET;
        cfg_range = RANGE_RESET;
        cfg_hold = HOLD_RESET;
        env_lvl = 0;
        gain_lvl = 0;
        hold_cnt = 0;
        open_st = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_edge_cases();
        test_setting_sweep();
        test_output_backpressure();

        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
